FILE: design/crng_pkg.sv
// ----------------------------------------------------------------------------
// crng_pkg
// Shared types, codes and constants of the combined LCG random core.
// ----------------------------------------------------------------------------
`default_nettype none

package crng_pkg;

    localparam int VALUE_W  = 31;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W   = $clog2(VALUE_W);

    localparam int CMD_QUEUE_DEPTH = 2;

    // first generator: x <- 48271 * x mod (2^31 - 1)
    localparam logic [VALUE_W-1:0] MOD_FIRST  = 31'd2147483647;
    localparam logic [15:0]        MUL_FIRST  = 16'd48271;
    // second generator: y <- 40692 * y mod (2^31 - 249)
    localparam logic [VALUE_W-1:0] MOD_SECOND = 31'd2147483399;
    localparam logic [15:0]        MUL_SECOND = 16'd40692;
    // 2^31 mod MOD_SECOND
    localparam logic [7:0]         FOLD_SECOND = 8'd249;
    localparam logic [VALUE_W-1:0] SPAN       = 31'd2147483646;

    localparam logic [VALUE_W-1:0] SEED_RESET = 31'd123;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_RAW     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOUNDED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 1'b1;

    typedef enum logic [1:0] {
        OP_RAW,
        OP_BOUNDED,
        OP_RESEED,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] k;
    } cmd_item_t;

endpackage

`default_nettype wire

FILE: design/crng_front.sv
// ----------------------------------------------------------------------------
// crng_front
// Accepts command items, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crng_front
    import crng_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [VALUE_W-1:0] bound,
    output logic                    q_valid,
    output cmd_item_t               q_head,
    input  wire logic               q_take
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    cmd_item_t              item_in;
    logic                   do_push;
    logic                   do_pop;

    // decode and clamp the bound to 1..SPAN
    always_comb
    begin
        case (cmd)
            CMD_RAW:     item_in.op = OP_RAW;
            CMD_BOUNDED: item_in.op = OP_BOUNDED;
            CMD_RESEED:  item_in.op = OP_RESEED;
            default:     item_in.op = OP_NOP;
        endcase
        if (bound == '0)
            item_in.k = VALUE_W'(1);
        else if (bound > SPAN)
            item_in.k = SPAN;
        else
            item_in.k = bound;
    end

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

FILE: design/crng_div.sv
// ----------------------------------------------------------------------------
// crng_div
// Restoring radix-2 remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crng_div
    import crng_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [VALUE_W-1:0] divisor,
    output logic                    busy,
    output logic [VALUE_W-1:0]      rem
);

    logic                busy_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0]  dvd_reg;
    logic [VALUE_W-1:0]  dsr_reg;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    logic [VALUE_W:0]    trial;
    logic [VALUE_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[VALUE_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    // trial < 2*divisor, so the result always fits back into VALUE_W bits
    assign rem_next = (trial >= {1'b0, dsr_reg}) ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];

    assign busy = busy_reg;
    assign rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_W'(VALUE_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[VALUE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/crng_back.sv
// ----------------------------------------------------------------------------
// crng_back
// Executes queued commands: steps or reseeds both generators, runs the
// rejection test and reduction mod k, and holds each result until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module crng_back
    import crng_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  cmd_item_t                 q_head,
    output logic                      q_take,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_W-1:0]   cfg_wdata,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [VALUE_W-1:0]        value
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_RED  = 5'b00100,
        ST_COMB = 5'b01000,
        ST_DIV  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   seed_first_reg, seed_second_reg;
    logic [VALUE_W-1:0]   gen_first_reg, gen_second_reg;
    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   value_reg;
    op_t                  op_reg;
    logic [VALUE_W-1:0]   k_reg;
    logic [VALUE_W-1:0]   z_reg;
    logic [46:0]          prod_first_reg, prod_second_reg;

    logic [VALUE_W:0]     red_first_sum, red_second_sum;
    logic [23:0]          fold_second;
    logic [VALUE_W-1:0]   red_first, red_second;
    logic [VALUE_W-1:0]   san_first, san_second;
    logic [VALUE_W:0]     z_diff;
    logic [VALUE_W-1:0]   z_comb;
    logic [VALUE_W-1:0]   limit;
    logic                 span_start, z_start;
    logic                 span_busy, z_busy;
    logic [VALUE_W-1:0]   span_rem, z_rem;
    logic                 start_item;
    logic                 div_done;
    logic                 draw_ok;

    // mod 2^31-1: fold the high part back onto the low part
    assign red_first_sum = {1'b0, prod_first_reg[30:0]} + (VALUE_W + 1)'(prod_first_reg[46:31]);
    assign red_first = (red_first_sum >= {1'b0, MOD_FIRST}) ?
                       VALUE_W'(red_first_sum - {1'b0, MOD_FIRST}) : red_first_sum[VALUE_W-1:0];

    // mod 2^31-249: high part weighs 249
    assign fold_second    = prod_second_reg[46:31] * FOLD_SECOND;
    assign red_second_sum = {1'b0, prod_second_reg[30:0]} + (VALUE_W + 1)'(fold_second);
    assign red_second = (red_second_sum >= {1'b0, MOD_SECOND}) ?
                        VALUE_W'(red_second_sum - {1'b0, MOD_SECOND}) :
                        red_second_sum[VALUE_W-1:0];

    // seeds reduced into range, zero replaced by one
    always_comb
    begin
        san_first  = (seed_first_reg == MOD_FIRST) ? '0 : seed_first_reg;
        san_second = (seed_second_reg >= MOD_SECOND) ? seed_second_reg - MOD_SECOND
                                                     : seed_second_reg;
        if (san_first == '0)
            san_first = VALUE_W'(1);
        if (san_second == '0)
            san_second = VALUE_W'(1);
    end

    assign z_diff = {1'b0, gen_first_reg} - {1'b0, gen_second_reg};
    assign z_comb = (gen_first_reg <= gen_second_reg) ? VALUE_W'(z_diff + {1'b0, SPAN})
                                                      : z_diff[VALUE_W-1:0];

    assign limit    = SPAN - span_rem;
    assign div_done = !span_busy && !z_busy;
    assign draw_ok  = (z_reg <= limit);

    assign start_item = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;
    assign q_take     = start_item;
    assign span_start = start_item && (q_head.op == OP_BOUNDED);
    assign z_start    = (state_reg == ST_COMB) && (op_reg == OP_BOUNDED);

    assign empty = !out_valid_reg;
    assign value = value_reg;

    crng_div u_span_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (span_start),
        .dividend (SPAN),
        .divisor  (q_head.k),
        .busy     (span_busy),
        .rem      (span_rem)
    );

    // z is captured as it is formed, in the same cycle it lands in z_reg
    crng_div u_z_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (z_start),
        .dividend (z_comb),
        .divisor  (k_reg),
        .busy     (z_busy),
        .rem      (z_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_item && (q_head.op == OP_RAW || q_head.op == OP_BOUNDED))
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_RED;
            ST_RED:  state_next = ST_COMB;
            ST_COMB: state_next = (op_reg == OP_BOUNDED) ? ST_DIV : ST_IDLE;
            ST_DIV:
            begin
                if (div_done)
                    state_next = draw_ok ? ST_IDLE : ST_MUL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seed_first_reg  <= SEED_RESET;
            seed_second_reg <= SEED_RESET;
            gen_first_reg   <= SEED_RESET;
            gen_second_reg  <= SEED_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                if (cfg_index == REG_SEED_FIRST)
                    seed_first_reg <= cfg_wdata;
                else if (cfg_index == REG_SEED_SECOND)
                    seed_second_reg <= cfg_wdata;
            end

            if (start_item && q_head.op == OP_RESEED)
            begin
                gen_first_reg  <= san_first;
                gen_second_reg <= san_second;
            end
            else if (state_reg == ST_RED)
            begin
                gen_first_reg  <= red_first;
                gen_second_reg <= red_second;
            end

            if (start_item && (q_head.op == OP_RESEED || q_head.op == OP_NOP))
                out_valid_reg <= 1'b1;
            else if (state_reg == ST_COMB && op_reg == OP_RAW)
                out_valid_reg <= 1'b1;
            else if (state_reg == ST_DIV && div_done && draw_ok)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            op_reg <= q_head.op;
            k_reg  <= q_head.k;
            if (q_head.op == OP_RESEED || q_head.op == OP_NOP)
                value_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_first_reg  <= gen_first_reg * MUL_FIRST;
            prod_second_reg <= gen_second_reg * MUL_SECOND;
        end
        if (state_reg == ST_COMB)
        begin
            z_reg <= z_comb;
            if (op_reg == OP_RAW)
                value_reg <= z_comb;
        end
        if (state_reg == ST_DIV && div_done && draw_ok)
            value_reg <= z_rem;
    end

    // generators never leave their nonzero ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        gen_first_reg != '0 && gen_first_reg < MOD_FIRST &&
        gen_second_reg != '0 && gen_second_reg < MOD_SECOND)
        else $error("generator state out of range");

    // no new work starts while a result is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !q_take)
        else $error("item started while result pending");

    // a bounded result is always below its bound k
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && op_reg == OP_BOUNDED |-> value_reg < k_reg)
        else $error("bounded result not below k");

    // reseed and unused commands return zero
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && (op_reg == OP_RESEED || op_reg == OP_NOP)
        |-> value_reg == '0)
        else $error("reseed or unused command returned nonzero");

    // a finished division always leaves the back end in a draw or idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && div_done |=> state_reg == ST_IDLE || state_reg == ST_MUL)
        else $error("bad exit from division wait");

endmodule

`default_nettype wire

FILE: design/combined_lcg_uniform_random_core.sv
// ----------------------------------------------------------------------------
// combined_lcg_uniform_random_core
// Combined two-generator Lehmer random source with raw, bounded and reseed
// commands.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  command   | push / full            | cmd[1:0], bound[30:0]
//  result    | empty / pop            | value[30:0]
//  config    | cfg_wr_en (no wait)    | cfg_index[0:0], cfg_wdata[30:0]
//
//  Raw draw: the back end steps through multiply, reduce and combine states.
//  Bounded draw: each try also waits for the 31-step remainder unit, and a
//  rejected try returns to multiply. Reseed and unused commands need no draw.
//  The back end runs one item at a time; the command queue keeps accepting
//  while a result waits to be popped. No clearing pass after reset.
//  Reset sets both seeds and both generators to 123.
// ----------------------------------------------------------------------------
`default_nettype none

module combined_lcg_uniform_random_core
    import crng_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [VALUE_W-1:0]   bound,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [VALUE_W-1:0]        value,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_W-1:0]   cfg_wdata
);

    logic      q_valid;
    logic      q_take;
    cmd_item_t q_head;

    crng_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .bound   (bound),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_take  (q_take)
    );

    crng_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_take    (q_take),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .empty     (empty),
        .pop       (pop),
        .value     (value)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the combined LCG random core. Commands go in
// through the push/full queue port and results come back through empty/pop.
// A local predictor steps both Lehmer generators, models bounded draws with
// rejection, reseeding and the seed registers, and each popped value is
// compared with the oldest expected value. Both sides idle at random, and
// one phase holds the result side off long enough to fill the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crng_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [CMD_W-1:0]     cmd;
    logic [VALUE_W-1:0]   bound;
    logic                 empty;
    logic                 pop;
    logic [VALUE_W-1:0]   value;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]   cfg_wdata;

    // predictor state
    logic [VALUE_W-1:0] first_seed   = SEED_RESET;
    logic [VALUE_W-1:0] second_seed  = SEED_RESET;
    logic [VALUE_W-1:0] first_state  = SEED_RESET;
    logic [VALUE_W-1:0] second_state = SEED_RESET;

    logic [VALUE_W-1:0] pending_values[$];
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_request = 0;

    combined_lcg_uniform_random_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .bound     (bound),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic logic [VALUE_W-1:0] lehmer_step(logic [VALUE_W-1:0] v,
                                                       longint unsigned mul,
                                                       longint unsigned m);
        longint unsigned prod;
        prod = longint'(v) * mul;
        return VALUE_W'(prod % m);
    endfunction

    function automatic logic [VALUE_W-1:0] seed_to_state(logic [VALUE_W-1:0] s,
                                                         longint unsigned m);
        longint unsigned r;
        r = longint'(s) % m;
        return (r == 0) ? VALUE_W'(1) : VALUE_W'(r);
    endfunction

    // steps both generators and combines them into 1..2^31-2
    function automatic logic [VALUE_W-1:0] combined_draw();
        longint z;
        first_state  = lehmer_step(first_state, MUL_FIRST, MOD_FIRST);
        second_state = lehmer_step(second_state, MUL_SECOND, MOD_SECOND);
        z = longint'(first_state) - longint'(second_state);
        if (z <= 0)
            z += longint'(SPAN);
        return VALUE_W'(z);
    endfunction

    function automatic logic [VALUE_W-1:0] expected_value(op_t op,
                                                          logic [VALUE_W-1:0] k_in);
        longint unsigned k;
        longint unsigned ceiling;
        longint unsigned u;
        case (op)
            OP_RAW:
                return combined_draw();
            OP_BOUNDED:
            begin
                k = (k_in == 0) ? 1 : k_in;
                if (k > SPAN)
                    k = SPAN;
                ceiling = k * (longint'(SPAN) / k);
                do
                    u = combined_draw();
                while (u > ceiling);
                return VALUE_W'(u % k);
            end
            OP_RESEED:
            begin
                first_state  = seed_to_state(first_seed, MOD_FIRST);
                second_state = seed_to_state(second_seed, MOD_SECOND);
                return '0;
            end
            default:
                return '0;
        endcase
    endfunction

    // offers one item; push stays high after acceptance until the next call
    task automatic send_item(op_t op, logic [VALUE_W-1:0] k_in);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push  = 1'b1;
        cmd   = op;
        bound = k_in;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_values.push_back(expected_value(op, k_in));
    endtask

    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == REG_SEED_FIRST)
            first_seed = data;
        else
            second_seed = data;
    endtask

    function automatic op_t random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_RAW;
        else if (r < 85)
            return OP_BOUNDED;
        else if (r < 95)
            return OP_RESEED;
        return OP_NOP;
    endfunction

    function automatic logic [VALUE_W-1:0] random_bound();
        logic [VALUE_W-1:0] k;
        k = VALUE_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = VALUE_W'($urandom_range(0, 64));
            5, 6:          k = VALUE_W'($urandom);
            // around half the span: rejection is frequent just above it
            7:             k = VALUE_W'($urandom_range(32'h3FFF_FFF8, 32'h4000_0008));
            8:             k = VALUE_W'($urandom_range(32'h7FFF_FFFA, 32'h7FFF_FFFF));
            default:       k = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
        endcase
        return k;
    endfunction

    // reset seeds are 123: a reseed must replay the first draw
    task automatic test_reset_state();
        send_item(OP_RAW, '0);
        send_item(OP_RAW, '0);
        send_item(OP_RESEED, '0);
        send_item(OP_RAW, '0);
    endtask

    task automatic test_command_fields();
        send_item(OP_BOUNDED, '0);
        send_item(OP_BOUNDED, VALUE_W'(1));
        send_item(OP_BOUNDED, VALUE_W'(2));
        send_item(OP_BOUNDED, VALUE_W'(3));
        send_item(OP_BOUNDED, '1);
        send_item(OP_BOUNDED, SPAN);
        send_item(OP_BOUNDED, VALUE_W'(32'h4000_0001));
        send_item(OP_BOUNDED, VALUE_W'(32'h4000_0001));
        send_item(OP_BOUNDED, VALUE_W'(32'h2AAA_AAAA));
        send_item(OP_BOUNDED, VALUE_W'(32'h5555_5555));
        send_item(OP_NOP, '1);
        send_item(OP_RAW, '1);
    endtask

    task automatic test_seed_registers();
        logic [VALUE_W-1:0] first_list[4];
        logic [VALUE_W-1:0] second_list[4];
        first_list  = '{'0, '1, MOD_FIRST - 1, MOD_SECOND};
        second_list = '{'0, '1, MOD_SECOND - 1, MOD_SECOND};
        foreach (first_list[i])
        begin
            settle();
            write_seed(REG_SEED_FIRST, first_list[i]);
            write_seed(REG_SEED_SECOND, second_list[i]);
            send_item(OP_RESEED, '0);
            send_item(OP_RAW, '0);
        end
    endtask

    task automatic test_random_traffic(int count);
        settle();
        write_seed(REG_SEED_FIRST, VALUE_W'($urandom));
        write_seed(REG_SEED_SECOND, VALUE_W'($urandom));
        for (int i = 0; i < count; i++)
            send_item(random_op(), random_bound());
    endtask

    // receiver stalls while the sender keeps offering, so full must rise
    task automatic test_backpressure();
        settle();
        hold_request = 300;
        for (int i = 0; i < 16; i++)
            send_item((i % 3 == 2) ? OP_BOUNDED : OP_RAW, VALUE_W'($urandom_range(0, 9)));
    endtask

    // result side: random pop, with an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pop = 1'b0;
                hold_left--;
            end
            else
                pop = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [VALUE_W-1:0] want;
        if (rst_n && pop && !empty)
        begin
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d", $time, value);
                mismatches++;
            end
            else
            begin
                want = pending_values.pop_front();
                if (value !== want)
                begin
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, want, value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        cmd       = CMD_RAW;
        bound     = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SEED_FIRST;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 63;
        test_reset_state();
        test_command_fields();
        test_seed_registers();
        test_random_traffic(320);

        send_idle_pct = 63;
        recv_idle_pct = 24;
        test_random_traffic(320);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(310);

        settle();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("%0t: timeout with %0d items outstanding", $time, pending_values.size());
        $display("FAIL");
        $finish;
    end

endmodule
